FILE: rtl/rde_pkg.sv
// Shared definitions for the radix digit emitter: defaults, symbol codes,
// register map and the configuration bundle. No dependencies.
`default_nettype none
package rde_pkg;

  localparam int MAX_BASE_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_NUL   = 8'h00;

  // Register map: 64-bit registers at byte address 8*index.
  localparam int CFG_ADDR_W = 5;
  localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_ALPHABET_LOW = 2'd1;
  localparam logic [1:0] REG_ALPHABET_HI  = 2'd2;

  localparam int GLYPHS = 16;

  typedef struct packed {
    logic [4:0]             radix;
    logic [GLYPHS-1:0][7:0] glyphs;
  } alpha_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/rde_front.sv
// Front end: checks the alphabet and splits each value into sign and magnitude.
// Depends on rde_pkg.
`default_nettype none
module rde_front
  import rde_pkg::*;
#(
  parameter int MAX_BASE   = MAX_BASE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         start,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire alpha_cfg_t                   cfg,
  input  wire logic                         queue_full,
  output logic                              busy,
  output logic                              push,
  output logic                              push_neg,
  output logic [VALUE_BITS-1:0]             push_mag
);

  logic                  alpha_ok;
  logic [VALUE_BITS-1:0] raw;

  // The alphabet is usable when the radix is in range and every used glyph
  // is unique and none of NUL, minus or plus.
  always_comb begin
    alpha_ok = (cfg.radix >= 5'd2) && (cfg.radix <= 5'(MAX_BASE));
    for (int i = 0; i < GLYPHS; i++) begin
      if (5'(i) < cfg.radix) begin
        if (cfg.glyphs[i] == SYM_NUL || cfg.glyphs[i] == SYM_MINUS ||
            cfg.glyphs[i] == SYM_PLUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < GLYPHS; j++) begin
          if (5'(j) < cfg.radix && cfg.glyphs[j] == cfg.glyphs[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // The two's complement negation of the most negative value is itself,
  // which read as unsigned is exactly its magnitude.
  assign raw      = $unsigned(value);
  assign push_neg = raw[VALUE_BITS-1];
  assign push_mag = push_neg ? ((~raw) + VALUE_BITS'(1)) : raw;

  assign busy = queue_full;
  // Words taken while the alphabet is invalid produce nothing and are dropped.
  assign push = start && !queue_full && alpha_ok;

endmodule
`default_nettype wire

FILE: rtl/rde_queue.sv
// Two-entry queue that carries sign and magnitude from the front to the back.
// Does not depend on rde_pkg; it is width generic.
`default_nettype none
module rde_queue #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  valid,
  output logic [WIDTH-1:0]      head
);

  logic [1:0][WIDTH-1:0] slots;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

endmodule
`default_nettype wire

FILE: rtl/rde_back.sv
// Back end: long division by the radix eight bits a cycle, a digit stack,
// and the character emitter. Depends on rde_pkg.
`default_nettype none
module rde_back
  import rde_pkg::*;
#(
  parameter int MAX_BASE   = MAX_BASE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire alpha_cfg_t            cfg,
  input  wire logic                  q_valid,
  input  wire logic                  q_neg,
  input  wire logic [VALUE_BITS-1:0] q_mag,
  output logic                       pop,
  output logic                       strobe,
  output logic [7:0]                 symbol,
  output logic                       last
);

  localparam int STEP_BITS = 8;
  localparam int CHUNKS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W     = CHUNKS * STEP_BITS;
  localparam int CNT_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DIGIT_W   = $clog2(MAX_BASE);
  localparam int REM_W     = DIGIT_W + 1;
  localparam int ND_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W     = $clog2(VALUE_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                             state;
  logic [CNT_W-1:0]                   chunk;
  logic [REM_W-1:0]                   rem;
  logic [PAD_W-1:0]                   work;
  logic [ND_W-1:0]                    nd;
  logic                               neg;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] digits;

  logic [REM_W-1:0] rem_next;
  logic [PAD_W-1:0] work_next;
  logic [REM_W-1:0] radix_w;
  logic [ND_W-1:0]  nd_m1;
  logic [3:0]       glyph_idx;
  logic             last_chunk;

  assign radix_w    = REM_W'(cfg.radix);
  assign last_chunk = (chunk == CNT_W'(CHUNKS - 1));
  assign nd_m1      = nd - ND_W'(1);
  assign glyph_idx  = 4'(digits[nd_m1[IDX_W-1:0]]);

  // One slice of restoring division: each step brings down the next dividend
  // bit and shifts the quotient bit into the bottom of the same register.
  always_comb begin
    rem_next  = rem;
    work_next = work;
    for (int k = 0; k < STEP_BITS; k++) begin
      rem_next  = {rem_next[REM_W-2:0], work_next[PAD_W-1]};
      work_next = {work_next[PAD_W-2:0], 1'b0};
      if (rem_next >= radix_w) begin
        rem_next     = rem_next - radix_w;
        work_next[0] = 1'b1;
      end
    end
  end

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      chunk  <= '0;
      nd     <= '0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            work  <= PAD_W'(q_mag);
            neg   <= q_neg;
            rem   <= '0;
            chunk <= '0;
            nd    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          work <= work_next;
          if (last_chunk) begin
            digits[nd[IDX_W-1:0]] <= rem_next[DIGIT_W-1:0];
            nd    <= nd + ND_W'(1);
            rem   <= '0;
            chunk <= '0;
            if (work_next == '0) begin
              state <= neg ? S_SIGN : S_EMIT;
            end
          end else begin
            rem   <= rem_next;
            chunk <= chunk + CNT_W'(1);
          end
        end
        S_SIGN: begin
          strobe <= 1'b1;
          symbol <= SYM_MINUS;
          last   <= 1'b0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          symbol <= cfg.glyphs[glyph_idx];
          last   <= (nd == ND_W'(1));
          nd     <= nd_m1;
          if (nd == ND_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Characters of one value leave on consecutive cycles.
  a_no_gap : assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a character run");

  a_last_marked : assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last flag without a character");

  a_stack_nonempty : assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> (nd != '0 && nd <= ND_W'(VALUE_BITS)))
    else $error("digit stack out of range while emitting");

  a_pop_idle : assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_DIV)
    else $error("value popped without starting a division");

endmodule
`default_nettype wire

FILE: rtl/radix_digit_emitter.sv
// Radix digit emitter top level: APB register file, front end, queue, back end.
// Sequence: after a value is loaded, each digit is found by dividing the whole
// magnitude by the radix, then an optional minus sign and the digits are emitted.
// Occupancy: one value at a time in the divider, which takes a new value only
// when idle after the last digit of the previous one; the queue holds two more.
// Reset: synchronous, clears control state and the configuration registers to 0 (invalid).
`default_nettype none
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int MAX_BASE   = MAX_BASE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Command side: a word is taken when start is high and busy is low.
  input  wire logic                         start,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output logic                              busy,
  // Result side: one character per strobe; the receiver cannot stall.
  output logic                              strobe,
  output logic [7:0]                        symbol,
  output logic                              last,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [CFG_ADDR_W-1:0]        paddr,
  input  wire logic [63:0]                  pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  // Register file. The radix keeps only the low five bits written to it.
  logic [4:0]  base_length;
  logic [63:0] alphabet_low;
  logic [63:0] alphabet_high;
  logic [1:0]  reg_sel;
  logic        cfg_write;

  alpha_cfg_t cfg;

  logic                  queue_full;
  logic                  push;
  logic                  push_neg;
  logic [VALUE_BITS-1:0] push_mag;
  logic                  pop;
  logic                  q_valid;
  logic [VALUE_BITS:0]   q_head;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  // A write to the unused fourth slot is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length   <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BASE_LENGTH:  base_length   <= pwdata[4:0];
        REG_ALPHABET_LOW: alphabet_low  <= pwdata;
        REG_ALPHABET_HI:  alphabet_high <= pwdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE_LENGTH:  prdata = 64'(base_length);
      REG_ALPHABET_LOW: prdata = alphabet_low;
      REG_ALPHABET_HI:  prdata = alphabet_high;
      default:          prdata = '0;
    endcase
  end

  // Glyph i sits in byte i of the 128-bit alphabet, low register first.
  assign cfg.radix  = base_length;
  assign cfg.glyphs = {alphabet_high, alphabet_low};

  // The front end checks the alphabet and forms sign and magnitude in the
  // cycle a word is taken; words seen with an invalid alphabet are dropped.
  rde_front #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .start      (start),
    .value      (value),
    .cfg        (cfg),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .push_neg   (push_neg),
    .push_mag   (push_mag)
  );

  // The queue lets new words arrive while the back end is still dividing.
  rde_queue #(
    .WIDTH (VALUE_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_neg, push_mag}),
    .pop       (pop),
    .full      (queue_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  // The back end divides by the radix until the quotient is zero, stacking
  // digits least significant first, then plays them out most significant
  // first after an optional minus sign.
  rde_back #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_neg   (q_head[VALUE_BITS]),
    .q_mag   (q_head[VALUE_BITS-1:0]),
    .pop     (pop),
    .strobe  (strobe),
    .symbol  (symbol),
    .last    (last)
  );

endmodule
`default_nettype wire
